// ===== rtl/core/mp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp_pkg
// shared constants, controller states and command/status structs for the
// modular power core
// ----------------------------------------------------------------------------
package mp_pkg;

    localparam logic [29:0] MODULUS    = 30'd998244353;
    localparam logic [29:0] MOD_M1     = 30'd998244352;
    // barrett reciprocal floor(2^60 / modulus)
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd998244353);
    // residues of 2^30 and 2^60, used to fold the base
    localparam logic [29:0] POW30_MOD  = 30'((64'd1 << 30) % 64'(MODULUS));
    localparam logic [29:0] POW60_MOD  = 30'((64'd1 << 60) % 64'(MODULUS));
    // multiple of M-1 above any folded exponent magnitude
    localparam logic [48:0] NEG_EXP_BIAS = 49'(64'(MOD_M1) << 19);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE_LO,
        ST_REDUCE_HI,
        ST_FIXUP,
        ST_ISSUE_SQ,
        ST_ISSUE_MUL,
        ST_WAIT,
        ST_FINISH
    } mp_state_t;

    typedef enum logic [1:0] {
        DST_SQ,
        DST_ACC,
        DST_RED
    } mp_dest_t;

    typedef struct packed {
        logic start;
        logic reduce_lo;
        logic reduce_hi;
        logic fixup;
        logic issue_sq;
        logic issue_mul;
        logic load_out;
    } mp_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic exp_zero;
        logic exp_lsb;
    } mp_status_t;

endpackage

// ===== rtl/core/mp_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp_modmul
// three-stage modular multiplier, product then barrett reduction, with a
// destination tag carried alongside each operation
// ----------------------------------------------------------------------------
module mp_modmul
    import mp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  mp_dest_t    op_dest,
    input  logic [29:0] op_a,
    input  logic [29:0] op_b,
    output logic        wb_valid,
    output mp_dest_t    wb_dest,
    output logic [29:0] wb_value,
    output logic        busy
);

    localparam logic [31:0] ModW  = {2'b00, MODULUS};
    localparam logic [31:0] TwoMW = {1'b0, MODULUS, 1'b0};

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    mp_dest_t    s1_dest_reg, s2_dest_reg, s3_dest_reg;
    logic [59:0] s1_prod_reg;
    logic [31:0] s2_plow_reg, s3_plow_reg;
    logic [61:0] s2_q2_reg;
    logic [31:0] s3_t_reg;

    logic [59:0] s1_prod_next;
    logic [61:0] s2_q2_next;
    logic [60:0] t_full;
    logic [31:0] s3_t_next;
    logic [31:0] rem;

    assign s1_prod_next = {30'd0, op_a} * {30'd0, op_b};
    assign s2_q2_next   = {31'd0, s1_prod_reg[59:29]} * {31'd0, BARRETT_MU};
    assign t_full       = {30'd0, s2_q2_reg[61:31]} * {31'd0, MODULUS};
    assign s3_t_next    = t_full[31:0];

    // remainder lies in 0..3M-1, so the low 32 bits are exact
    assign rem = s3_plow_reg - s3_t_reg;

    always_comb
    begin
        if (rem >= TwoMW)
        begin
            wb_value = 30'(rem - TwoMW);
        end
        else if (rem >= ModW)
        begin
            wb_value = 30'(rem - ModW);
        end
        else
        begin
            wb_value = rem[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= op_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dest_reg <= op_dest;
        s1_prod_reg <= s1_prod_next;
        s2_dest_reg <= s1_dest_reg;
        s2_plow_reg <= s1_prod_reg[31:0];
        s2_q2_reg   <= s2_q2_next;
        s3_dest_reg <= s2_dest_reg;
        s3_plow_reg <= s2_plow_reg;
        s3_t_reg    <= s3_t_next;
    end

    assign wb_valid = s3_valid_reg;
    assign wb_dest  = s3_dest_reg;
    assign busy     = s1_valid_reg | s2_valid_reg | s3_valid_reg;

endmodule

// ===== rtl/core/mp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp_datapath
// input capture, base reduction through the shared modular multiplier,
// exponent folding, square and multiply registers, result register
// ----------------------------------------------------------------------------
module mp_datapath
    import mp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mp_cmd_t     cmd,
    input  logic [63:0] base,
    input  logic [63:0] exponent,
    output mp_status_t  status,
    output logic [29:0] power,
    output logic        no_inverse
);

    logic [63:0] bmag_reg, bmag_next;
    logic [63:0] emag_reg, emag_next;
    logic        bneg_reg, bneg_next;
    logic        eneg_reg, eneg_next;
    logic [29:0] rb_reg, rb_next;
    logic [47:0] re_reg, re_next;
    logic [62:0] e_reg, e_next;
    logic [29:0] acc_reg, acc_next;
    logic [29:0] sq_reg, sq_next;
    logic        noinv_reg, noinv_next;
    logic [29:0] power_reg, power_next;
    logic        no_inverse_reg, no_inverse_next;

    logic [29:0] lo_step;
    logic [30:0] rb_sum;
    logic [29:0] rb_acc;
    logic [24:0] efold;
    logic [29:0] a_val;
    logic        fix_noinv;
    logic [62:0] e_fix;

    logic        mul_valid;
    mp_dest_t    mul_dest;
    logic [29:0] mul_a;
    logic [29:0] mul_b;
    logic        wb_valid;
    mp_dest_t    wb_dest;
    logic [29:0] wb_value;
    logic        mul_busy;

    // low 30 base bits by compare and subtract, upper parts through the multiplier
    assign lo_step = (bmag_reg[29:0] >= MODULUS) ? (bmag_reg[29:0] - MODULUS)
                                                 : bmag_reg[29:0];
    assign rb_sum  = {1'b0, rb_reg} + {1'b0, wb_value};
    assign rb_acc  = (rb_sum >= {1'b0, MODULUS}) ? 30'(rb_sum - {1'b0, MODULUS})
                                                  : rb_sum[29:0];

    // m-1 = 119 * 2^23 and 2^24 == 1 mod 119, so bits 63:23 fold into 25 bits
    assign efold = {1'b0, emag_reg[46:23]} + {8'd0, emag_reg[63:47]};

    assign a_val     = (bneg_reg && (rb_reg != 30'd0)) ? (MODULUS - rb_reg) : rb_reg;
    assign fix_noinv = eneg_reg && (a_val == 30'd0);

    // negative exponent maps to a multiple of m-1 minus the folded magnitude
    always_comb
    begin
        if (fix_noinv)
        begin
            e_fix = '0;
        end
        else if (eneg_reg)
        begin
            e_fix = {14'd0, NEG_EXP_BIAS - {1'b0, re_reg}};
        end
        else
        begin
            e_fix = e_reg;
        end
    end

    assign mul_valid = cmd.issue_sq | cmd.issue_mul | cmd.reduce_lo | cmd.reduce_hi;

    always_comb
    begin
        mul_dest = DST_SQ;
        mul_a    = sq_reg;
        mul_b    = sq_reg;
        if (cmd.reduce_lo)
        begin
            mul_dest = DST_RED;
            mul_a    = bmag_reg[59:30];
            mul_b    = POW30_MOD;
        end
        else if (cmd.reduce_hi)
        begin
            mul_dest = DST_RED;
            mul_a    = {26'd0, bmag_reg[63:60]};
            mul_b    = POW60_MOD;
        end
        else if (cmd.issue_mul)
        begin
            mul_dest = DST_ACC;
            mul_a    = acc_reg;
        end
    end

    mp_modmul u_modmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (mul_valid),
        .op_dest  (mul_dest),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .wb_valid (wb_valid),
        .wb_dest  (wb_dest),
        .wb_value (wb_value),
        .busy     (mul_busy)
    );

    always_comb
    begin
        bmag_next       = bmag_reg;
        emag_next       = emag_reg;
        bneg_next       = bneg_reg;
        eneg_next       = eneg_reg;
        rb_next         = rb_reg;
        re_next         = re_reg;
        e_next          = e_reg;
        acc_next        = acc_reg;
        sq_next         = sq_reg;
        noinv_next      = noinv_reg;
        power_next      = power_reg;
        no_inverse_next = no_inverse_reg;

        if (cmd.start)
        begin
            bmag_next = base[63] ? (~base + 64'd1) : base;
            emag_next = exponent[63] ? (~exponent + 64'd1) : exponent;
            bneg_next = base[63];
            eneg_next = exponent[63];
            e_next    = exponent[62:0];
        end

        if (cmd.reduce_lo)
        begin
            rb_next = lo_step;
            re_next = {efold, emag_reg[22:0]};
        end

        if (cmd.fixup)
        begin
            sq_next    = a_val;
            acc_next   = fix_noinv ? 30'd0 : 30'd1;
            noinv_next = fix_noinv;
            e_next     = e_fix;
        end

        if (cmd.issue_sq)
        begin
            e_next = {1'b0, e_reg[62:1]};
        end

        if (wb_valid)
        begin
            case (wb_dest)
                DST_ACC:
                begin
                    acc_next = wb_value;
                end
                DST_RED:
                begin
                    rb_next = rb_acc;
                end
                default:
                begin
                    sq_next = wb_value;
                end
            endcase
        end

        if (cmd.load_out)
        begin
            power_next      = acc_reg;
            no_inverse_next = noinv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bmag_reg       <= bmag_next;
        emag_reg       <= emag_next;
        bneg_reg       <= bneg_next;
        eneg_reg       <= eneg_next;
        rb_reg         <= rb_next;
        re_reg         <= re_next;
        e_reg          <= e_next;
        acc_reg        <= acc_next;
        sq_reg         <= sq_next;
        noinv_reg      <= noinv_next;
        power_reg      <= power_next;
        no_inverse_reg <= no_inverse_next;
    end

    assign status.mul_busy = mul_busy;
    assign status.exp_zero = (e_reg == '0);
    assign status.exp_lsb  = e_reg[0];

    assign power      = power_reg;
    assign no_inverse = no_inverse_reg;

endmodule

// ===== rtl/core/mp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp_ctrl
// sequencer for capture, reduction, square and multiply loop and result
// handoff, plus the handshake flags of both channels
// ----------------------------------------------------------------------------
module mp_ctrl
    import mp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       arg_valid,
    output logic       arg_stall,
    output logic       res_valid,
    input  logic       res_stall,
    input  mp_status_t status,
    output mp_cmd_t    cmd
);

    mp_state_t state_reg, state_next;
    logic      res_valid_reg, res_valid_next;
    logic      out_free;

    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (arg_valid)
                begin
                    state_next = ST_REDUCE_LO;
                end
            end
            ST_REDUCE_LO:
            begin
                state_next = ST_REDUCE_HI;
            end
            ST_REDUCE_HI:
            begin
                state_next = ST_FIXUP;
            end
            ST_FIXUP:
            begin
                if (!status.mul_busy)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_ISSUE_SQ:
            begin
                state_next = status.exp_lsb ? ST_ISSUE_MUL : ST_WAIT;
            end
            ST_ISSUE_MUL:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!status.mul_busy)
                begin
                    state_next = status.exp_zero ? ST_FINISH : ST_ISSUE_SQ;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        arg_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                arg_stall = 1'b0;
                cmd.start = arg_valid;
            end
            ST_REDUCE_LO:
            begin
                cmd.reduce_lo = 1'b1;
            end
            ST_REDUCE_HI:
            begin
                cmd.reduce_hi = 1'b1;
            end
            ST_FIXUP:
            begin
                cmd.fixup = !status.mul_busy;
            end
            ST_ISSUE_SQ:
            begin
                cmd.issue_sq = 1'b1;
            end
            ST_ISSUE_MUL:
            begin
                cmd.issue_mul = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// ===== rtl/core/modular_power_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_power_core
// base^exponent mod 998244353 by right-to-left square and multiply, negative
// exponents through the fermat inverse
//
//   channel   handshake              payload
//   arg       arg_valid / arg_stall  base[63:0], exponent[63:0] (signed)
//   res       res_valid / res_stall  power[29:0], no_inverse
//
// one item at a time: accept, issue of the base folds, a wait until the reduced
// base is fixed up, a check, then per exponent bit a square and, when the bit
// is set, a multiply, each waiting on the three-stage shared multiplier;
// up to 63 bits for a nonnegative exponent, 48 or 49 for a negative one
// reset returns the sequencer to idle and empties the result register
// a stalled result holds; the next item is taken while it waits
// ----------------------------------------------------------------------------
module modular_power_core
    import mp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        arg_valid,
    output logic        arg_stall,
    input  logic [63:0] base,
    input  logic [63:0] exponent,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [29:0] power,
    output logic        no_inverse
);

    mp_cmd_t    cmd;
    mp_status_t status;

    mp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (arg_valid),
        .arg_stall (arg_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mp_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .base       (base),
        .exponent   (exponent),
        .status     (status),
        .power      (power),
        .no_inverse (no_inverse)
    );

endmodule

// ===== rtl/core/mp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp_checker
// port-level checks on the modular power core, bound to the top level
// ----------------------------------------------------------------------------
module mp_checker
    import mp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        arg_valid,
    input logic        arg_stall,
    input logic [63:0] base,
    input logic [63:0] exponent,
    input logic        res_valid,
    input logic        res_stall,
    input logic [29:0] power,
    input logic        no_inverse
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(power) && $stable(no_inverse))
        else $error("result changed while stalled");

    // power is a residue
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> power < MODULUS)
        else $error("power out of range");

    // missing inverse gives zero
    a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && no_inverse |-> power == 30'd0)
        else $error("no_inverse with nonzero power");

    // an accepted item keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        arg_valid && !arg_stall |=> arg_stall)
        else $error("second item taken right after accept");

endmodule

bind modular_power_core mp_checker u_mp_checker (.*);

// ===== verif/modular_power_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_power_core_test
// Self-checking bench for the modular power core. A directed set covers zero
// and negative exponents, bases divisible by the modulus and the most negative
// operands. A random set of 1450 items follows, each predicted on acceptance
// with a behavioral square-and-multiply. Every result is checked, field by
// field and in order. Outside a quiet span both channels idle and stall at random.
// ----------------------------------------------------------------------------
module modular_power_core_test;
    import mp_pkg::*;

    localparam int          RANDOM_ITEMS   = 1450;
    localparam int          DRAIN_CYCLES   = 600;
    localparam int          WATCHDOG_LIMIT = 6000;
    localparam int          QUIET_FIRST    = 500;
    localparam int          QUIET_LAST     = 800;
    localparam logic [63:0] PRIME          = 64'(MODULUS);
    localparam logic [63:0] PRIME_M1       = 64'(MOD_M1);
    localparam logic [63:0] MOST_NEG       = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS       = 64'h7fff_ffff_ffff_ffff;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] exponent;
    } power_arg_t;

    typedef struct packed {
        logic [29:0] power;
        logic        no_inverse;
    } power_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        arg_valid = 1'b0;
    logic        arg_stall;
    logic [63:0] base = '0;
    logic [63:0] exponent = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [29:0] power;
    logic        no_inverse;

    power_arg_t  pending_args[$];
    power_res_t  expected_powers[$];
    logic        arg_fire = 1'b0;
    int          args_taken = 0;
    int          error_count = 0;
    int          stuck_cycles;

    modular_power_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .arg_valid  (arg_valid),
        .arg_stall  (arg_stall),
        .base       (base),
        .exponent   (exponent),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .power      (power),
        .no_inverse (no_inverse)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] mod_product(input logic [63:0] x, input logic [63:0] y);
        return (x * y) % PRIME;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic power_res_t predict_power(input power_arg_t arg);
        power_res_t  res;
        logic [63:0] red_base;
        logic [63:0] exp_bits;
        logic [63:0] acc;
        logic [63:0] sq;
        res.power      = 30'd1;
        res.no_inverse = 1'b0;
        if (arg.exponent == 64'd0)
            return res;
        red_base = abs64(arg.base) % PRIME;
        if (arg.base[63] && red_base != 64'd0)
            red_base = PRIME - red_base;
        if (arg.exponent[63])
        begin
            if (red_base == 64'd0)
            begin
                res.power      = 30'd0;
                res.no_inverse = 1'b1;
                return res;
            end
            // fermat: a^-n == a^((M-1) - (n mod (M-1)))
            exp_bits = PRIME_M1 - (abs64(arg.exponent) % PRIME_M1);
        end
        else
        begin
            exp_bits = arg.exponent;
        end
        acc = 64'd1;
        sq  = red_base;
        for (int i = 0; i < 64; i++)
        begin
            if (exp_bits[0])
                acc = mod_product(acc, sq);
            sq       = mod_product(sq, sq);
            exp_bits = exp_bits >> 1;
        end
        res.power = acc[29:0];
        return res;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_sign(input logic [63:0] v);
        return $urandom_range(0, 1) ? (~v + 64'd1) : v;
    endfunction

    function automatic power_arg_t rand_arg();
        power_arg_t arg;
        int         pick;
        pick = $urandom_range(0, 99);
        arg.base     = rand_word();
        arg.exponent = rand_word();
        if (pick < 30)
            ;
        else if (pick < 45)
            arg.base = rand_sign(64'($urandom_range(0, 1000)));
        else if (pick < 62)
            arg.base = rand_sign(PRIME * 64'($urandom_range(0, 2000000)));
        else if (pick < 70)
            arg.exponent = 64'd0;
        else if (pick < 85)
            arg.exponent = rand_sign(64'($urandom_range(1, 70)));
        else
            arg.exponent = rand_sign(PRIME_M1 * 64'($urandom_range(0, 5000))
                                     + 64'($urandom_range(0, 3)));
        return arg;
    endfunction

    task automatic add_arg(input logic [63:0] b, input logic [63:0] e);
        pending_args.push_back('{base: b, exponent: e});
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            automatic bit quiet = args_taken >= QUIET_FIRST && args_taken < QUIET_LAST;
            if (!arg_valid || arg_fire)
            begin
                if (pending_args.size() > 0 && (quiet || $urandom_range(0, 99) >= 14))
                begin
                    automatic power_arg_t next_arg = pending_args.pop_front();
                    base      <= next_arg.base;
                    exponent  <= next_arg.exponent;
                    arg_valid <= 1'b1;
                end
                else
                begin
                    arg_valid <= 1'b0;
                end
            end
            res_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 14);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        arg_fire <= arg_valid && !arg_stall;
        if (arg_valid && !arg_stall)
        begin
            expected_powers.push_back(predict_power('{base: base, exponent: exponent}));
            args_taken <= args_taken + 1;
        end
        if (res_valid && !res_stall)
        begin
            if (expected_powers.size() == 0)
            begin
                $display("%0t: unexpected result power=%0d no_inverse=%0b",
                         $time, power, no_inverse);
                error_count = error_count + 1;
            end
            else
            begin
                automatic power_res_t want = expected_powers.pop_front();
                if (power !== want.power)
                begin
                    $display("%0t: power expected %0d actual %0d", $time, want.power, power);
                    error_count = error_count + 1;
                end
                if (no_inverse !== want.no_inverse)
                begin
                    $display("%0t: no_inverse expected %0b actual %0b",
                             $time, want.no_inverse, no_inverse);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((arg_valid && !arg_stall) || (res_valid && !res_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        // zero exponent, also for bases divisible by the modulus
        add_arg(64'd0, 64'd0);
        add_arg(PRIME, 64'd0);
        add_arg(MOST_NEG, 64'd0);
        add_arg(MOST_POS, 64'd0);
        // negative exponent with no inverse
        add_arg(64'd0, -64'd1);
        add_arg(PRIME, -64'd5);
        add_arg(-PRIME, MOST_NEG);
        add_arg(PRIME * 64'd7, -64'd1);
        // most negative and most positive operands
        add_arg(MOST_NEG, MOST_NEG);
        add_arg(MOST_NEG, MOST_POS);
        add_arg(MOST_POS, MOST_POS);
        add_arg(MOST_POS, MOST_NEG);
        add_arg(-64'd1, MOST_POS);
        add_arg(-64'd1, -64'd1);
        // plain and inverse powers
        add_arg(64'd2, 64'd1);
        add_arg(64'd2, -64'd1);
        add_arg(64'd3, PRIME_M1);
        add_arg(64'd5, -PRIME_M1);
        add_arg(64'd1, -64'd1);
        add_arg(PRIME - 64'd1, 64'd3);
        add_arg(PRIME * 64'd2 + 64'd1, 64'd1000);
        add_arg(-64'd2, 64'hffff_ffff);
        add_arg(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffe);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_args.push_back(rand_arg());

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_args.size() == 0);
        @(posedge clk);
        wait (!arg_valid);
        wait (expected_powers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_powers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mp_pkg.sv
rtl/core/mp_modmul.sv
rtl/core/mp_datapath.sv
rtl/core/mp_ctrl.sv
rtl/core/modular_power_core.sv
rtl/core/mp_checker.sv
verif/modular_power_core_test.sv
